// File: rtl/lfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER   = 2'd0;
   localparam logic [1:0] KIND_PIXEL    = 2'd1;
   localparam logic [1:0] KIND_CHECKSUM = 2'd2;
   localparam logic [1:0] KIND_PREFIX   = 2'd3;

   // parser phases
   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;

   // color phases within one pixel
   localparam logic [1:0] CP_RED   = 2'd0;
   localparam logic [1:0] CP_GREEN = 2'd1;
   localparam logic [1:0] CP_BLUE  = 2'd2;

   localparam logic [4:0] PREFIX_LEN = 5'd6;
   localparam logic [4:0] HDR_LEN    = 5'd21;
   localparam logic [4:0] HDR_CHECK  = 5'd20;

   // header byte positions that carry settings
   localparam logic [4:0] HDR_COUNT_LO = 5'd1;
   localparam logic [4:0] HDR_COUNT_HI = 5'd2;
   localparam logic [4:0] HDR_BRIGHT   = 5'd3;
   localparam logic [4:0] HDR_EFFECT   = 5'd7;
   localparam logic [4:0] HDR_LDR_EN   = 5'd8;
   localparam logic [4:0] HDR_LDR_OFF  = 5'd9;
   localparam logic [4:0] HDR_LDR_INT  = 5'd10;
   localparam logic [4:0] HDR_LDR_ACT  = 5'd12;

   localparam logic [7:0]  CHK_SEED         = 8'h55;
   localparam logic [15:0] DEFAULT_LEDS     = 16'd100;
   localparam logic [7:0]  MAX_WRITE_EFFECT = 8'd6;
   localparam logic [7:0]  EFFECT_CLEAR     = 8'd100;
   localparam logic [7:0]  WEIGHT_RESET     = 8'd255;
   localparam logic [7:0]  BRIGHT_RESET     = 8'd255;

   // configuration registers
   localparam int CSR_DATA_W = 48;
   localparam logic CSR_PREFIX = 1'b0;
   localparam logic CSR_WEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       sensor_reading;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] led_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        pixel_write;
      logic        last_pixel;
      logic [15:0] led_count;
      logic        count_changed;
      logic [7:0]  frame_brightness;
      logic [7:0]  effect_code;
   } rsp_type;

   typedef struct packed {
      logic [47:0] frame_prefix;
      logic [7:0]  count_high_weight;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/lfp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_parse import lfp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    step,
   input  wire req_type item,
   output logic         res_valid,
   output rsp_type      res
);

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [47:0] prefix_shift_ff, prefix_shift_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] pixel_count_ff, pixel_count_in;
   logic [1:0]  color_phase_ff, color_phase_in;
   logic [15:0] rg_ff, rg_in;
   logic [15:0] stored_count_ff, stored_count_in;
   logic [7:0]  effect_ff, effect_in;
   logic [7:0]  bright_ff, bright_in;
   logic [2:0]  ldr_ff, ldr_in;

   // header fields kept for the accept step
   logic [7:0]  cnt_lo_ff, cnt_lo_in;
   logic [7:0]  cnt_hi_ff, cnt_hi_in;
   logic [7:0]  hdr_bright_ff, hdr_bright_in;
   logic [7:0]  hdr_effect_ff, hdr_effect_in;
   logic        hdr_en_ff, hdr_en_in;
   logic        hdr_off_ff, hdr_off_in;
   logic        hdr_int_ff, hdr_int_in;
   logic        hdr_act_ff, hdr_act_in;

   logic [7:0]  b;
   logic [4:0]  k;
   logic [7:0]  xor_base;
   logic [4:0]  pre_base;
   logic [47:0] shift_base;
   logic [47:0] shift_new;
   logic [4:0]  pre_next;
   logic [15:0] prod;
   logic [15:0] new_count;
   logic        last;
   logic        produced;

   assign b    = item.rx_byte;
   assign prod = 16'(cfg.count_high_weight) * 16'(cnt_hi_ff);
   assign new_count = prod + 16'(cnt_lo_ff) + 16'd1;
   assign last = (pixel_count_ff + 16'd1) == stored_count_ff;

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      prefix_shift_in = prefix_shift_ff;
      xor_in          = xor_ff;
      pixel_count_in  = pixel_count_ff;
      color_phase_in  = color_phase_ff;
      rg_in           = rg_ff;
      stored_count_in = stored_count_ff;
      effect_in       = effect_ff;
      bright_in       = bright_ff;
      ldr_in          = ldr_ff;
      cnt_lo_in       = cnt_lo_ff;
      cnt_hi_in       = cnt_hi_ff;
      hdr_bright_in   = hdr_bright_ff;
      hdr_effect_in   = hdr_effect_ff;
      hdr_en_in       = hdr_en_ff;
      hdr_off_in      = hdr_off_ff;
      hdr_int_in      = hdr_int_ff;
      hdr_act_in      = hdr_act_ff;
      produced        = 1'b0;
      res             = '0;

      k          = (byte_count_ff < HDR_LEN) ? byte_count_ff : 5'd0;
      xor_base   = (k == 5'd0) ? CHK_SEED : xor_ff;
      pre_base   = (phase_ff != PH_PREFIX || byte_count_ff >= PREFIX_LEN) ?
                   5'd0 : byte_count_ff;
      shift_base = (pre_base == 5'd0) ? 48'd0 : prefix_shift_ff;
      shift_new  = {shift_base[39:0], b};
      pre_next   = pre_base + 5'd1;

      case (phase_ff)
         PH_HEADER: begin
            if (k < HDR_CHECK) begin
               xor_in        = xor_base ^ b;
               byte_count_in = k + 5'd1;
               case (k)
                  HDR_COUNT_LO: cnt_lo_in     = b;
                  HDR_COUNT_HI: cnt_hi_in     = b;
                  HDR_BRIGHT:   hdr_bright_in = b;
                  HDR_EFFECT:   hdr_effect_in = b;
                  HDR_LDR_EN:   hdr_en_in     = (b == 8'd1);
                  HDR_LDR_OFF:  hdr_off_in    = (b == 8'd1);
                  HDR_LDR_INT:  hdr_int_in    = (b != 8'd0);
                  HDR_LDR_ACT:  hdr_act_in    = b inside {8'd2, 8'd3, 8'd4};
                  default: ;
               endcase
            end else if (b != xor_base) begin
               phase_in        = PH_PREFIX;
               byte_count_in   = 5'd0;
               prefix_shift_in = 48'd0;
               produced        = 1'b1;
               res.kind        = KIND_CHECKSUM;
            end else begin
               if (!ldr_ff[0]) bright_in = hdr_bright_ff;
               if (hdr_act_ff) ldr_in = {hdr_int_ff, hdr_off_ff, hdr_en_ff};
               stored_count_in = new_count;
               if (hdr_effect_ff != 8'd0 && hdr_effect_ff != effect_ff)
                  effect_in = (hdr_effect_ff == EFFECT_CLEAR) ? 8'd0 : hdr_effect_ff;
               phase_in       = PH_PIXELS;
               pixel_count_in = 16'd0;
               color_phase_in = CP_RED;
               produced       = 1'b1;
               res.kind             = KIND_HEADER;
               res.led_count        = new_count;
               res.count_changed    = new_count != stored_count_ff;
               res.frame_brightness = bright_in;
               res.effect_code      = effect_in;
            end
         end
         PH_PIXELS: begin
            case (color_phase_ff)
               CP_RED: begin
                  rg_in[15:8]    = b;
                  color_phase_in = CP_GREEN;
               end
               CP_GREEN: begin
                  rg_in[7:0]     = b;
                  color_phase_in = CP_BLUE;
               end
               default: begin
                  produced             = 1'b1;
                  res.kind             = KIND_PIXEL;
                  res.led_index        = pixel_count_ff;
                  if (!(item.sensor_reading && ldr_ff == 3'b111)) begin
                     res.red   = rg_ff[15:8];
                     res.green = rg_ff[7:0];
                     res.blue  = b;
                  end
                  res.pixel_write      = effect_ff <= MAX_WRITE_EFFECT;
                  res.last_pixel       = last;
                  res.led_count        = stored_count_ff;
                  res.frame_brightness = bright_ff;
                  res.effect_code      = effect_ff;
                  color_phase_in       = CP_RED;
                  pixel_count_in       = pixel_count_ff + 16'd1;
                  if (last) begin
                     phase_in        = PH_PREFIX;
                     byte_count_in   = 5'd0;
                     prefix_shift_in = 48'd0;
                  end
               end
            endcase
         end
         default: begin
            // prefix collection, also taken for the unused phase code
            phase_in        = PH_PREFIX;
            prefix_shift_in = shift_new;
            byte_count_in   = pre_next;
            if (pre_next >= PREFIX_LEN) begin
               if (shift_new != cfg.frame_prefix) begin
                  byte_count_in   = 5'd0;
                  prefix_shift_in = 48'd0;
                  produced        = 1'b1;
                  res.kind        = KIND_PREFIX;
               end else begin
                  phase_in      = PH_HEADER;
                  byte_count_in = 5'd0;
                  xor_in        = CHK_SEED;
               end
            end
         end
      endcase
   end

   assign res_valid = step && produced;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         byte_count_ff   <= 5'd0;
         xor_ff          <= CHK_SEED;
         color_phase_ff  <= CP_RED;
         stored_count_ff <= DEFAULT_LEDS;
         effect_ff       <= 8'd0;
         bright_ff       <= BRIGHT_RESET;
         ldr_ff          <= 3'b000;
      end else if (step) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         xor_ff          <= xor_in;
         color_phase_ff  <= color_phase_in;
         stored_count_ff <= stored_count_in;
         effect_ff       <= effect_in;
         bright_ff       <= bright_in;
         ldr_ff          <= ldr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         prefix_shift_ff <= prefix_shift_in;
         pixel_count_ff  <= pixel_count_in;
         rg_ff           <= rg_in;
         cnt_lo_ff       <= cnt_lo_in;
         cnt_hi_ff       <= cnt_hi_in;
         hdr_bright_ff   <= hdr_bright_in;
         hdr_effect_ff   <= hdr_effect_in;
         hdr_en_ff       <= hdr_en_in;
         hdr_off_ff      <= hdr_off_in;
         hdr_int_ff      <= hdr_int_in;
         hdr_act_ff      <= hdr_act_in;
      end
   end

   a_pixel_in_range: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PIXEL |-> res.led_index < res.led_count)
      else $error("pixel index beyond led count");

   a_header_enters_pixels: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_HEADER |=>
         phase_ff == PH_PIXELS && color_phase_ff == CP_RED && pixel_count_ff == 16'd0)
      else $error("accepted header did not start pixel stream");

   a_error_restarts: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.kind == KIND_CHECKSUM || res.kind == KIND_PREFIX) |=>
         phase_ff == PH_PREFIX && byte_count_ff == 5'd0)
      else $error("error did not restart prefix collection");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PIXEL && res.last_pixel |=>
         phase_ff == PH_PREFIX && byte_count_ff == 5'd0)
      else $error("last pixel did not restart prefix collection");

endmodule

`default_nettype wire

// File: rtl/led_serial_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          direction  contents
// req       req_valid/req_ready/req_payload  in       one received byte, sensor flag
// rsp       rsp_valid/rsp_ready/rsp_payload  out      header, pixel or error result
// csr       csr_we/csr_index/csr_wdata       in       prefix and count weight writes
//
// one request per cycle sustained while rsp is not stalled; a result is presented on rsp
// after its request passes the input register, the parse logic, then the result register.
// reset is synchronous: parser goes to prefix collection with default settings.
// a stalled result holds in the result register while one more request is taken
// into the input register; the request side then stalls until rsp_ready.

module led_serial_frame_parser import lfp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        in_valid_ff;
   req_type     in_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;
   logic [47:0] prefix_ff;
   logic [7:0]  weight_ff;
   cfg_type     cfg;
   logic        step;
   logic        res_valid;
   rsp_type     res;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign cfg       = '{frame_prefix: prefix_ff, count_high_weight: weight_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 48'd0;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PREFIX: prefix_ff <= csr_wdata[47:0];
            CSR_WEIGHT: weight_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
   end

   lfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .item      (in_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      if (step) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire
